// File: rtl/gsnm_pkg.sv
// Package for the grid strip nonadjacent max sum block.
// Holds types, constants and elaboration-time pattern helpers; no dependencies.
package gsnm_pkg;

    localparam int CELL_W      = 32;
    localparam int TOT_W       = 64;
    localparam int SUM_W       = 36;
    localparam int CELL_FIELDS = 8;
    localparam int MAX_PAT     = 144;

    typedef logic signed [CELL_W-1:0] t_cell;
    typedef logic signed [TOT_W-1:0]  t_total;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_total TOT_MIN       = 64'sh8000000000000000;
    localparam t_total TOT_MAX       = 64'sh7FFFFFFFFFFFFFFF;
    localparam t_cell  LARGEST_RESET = -32'sd1000000000;

    typedef struct packed {
        logic load_sum;
        logic clr_best;
        logic sweep;
        logic rotate;
        logic update;
        logic first;
    } t_lane_ctl;

    typedef struct packed {
        logic clr;
        logic step;
    } t_merge_ctl;

    // number of row patterns with no two adjacent rows set
    function automatic int pat_count(input int rows);
        int n;
        n = 0;
        for (int m = 0; m < (1 << rows); m++)
            if ((m & (m >> 1)) == 0) n++;
        return n;
    endfunction

    // code of the k-th valid pattern in ascending order
    function automatic int pat_at(input int rows, input int k);
        int idx;
        int code;
        idx  = 0;
        code = 0;
        for (int m = 0; m < (1 << rows); m++) begin
            if ((m & (m >> 1)) == 0) begin
                if (idx == k) code = m;
                idx++;
            end
        end
        return code;
    endfunction

    // bit k set when the k-th valid pattern shares no row with mask
    function automatic logic [MAX_PAT-1:0] compat_vec(input int rows, input int mask);
        logic [MAX_PAT-1:0] v;
        int idx;
        v   = '0;
        idx = 0;
        for (int m = 0; m < (1 << rows); m++) begin
            if ((m & (m >> 1)) == 0) begin
                v[idx] = ((m & mask) == 0);
                idx++;
            end
        end
        return v;
    endfunction

endpackage

// File: rtl/gsnm_if.sv
// Channel interfaces: column beats in, result beats out.
// Depends on gsnm_pkg.
interface gsnm_in_if;
    import gsnm_pkg::*;
    logic  valid;
    logic  ready;
    t_cell cell_row0;
    t_cell cell_row1;
    t_cell cell_row2;
    t_cell cell_row3;
    t_cell cell_row4;
    t_cell cell_row5;
    t_cell cell_row6;
    t_cell cell_row7;
    logic  last_column;
    modport source(output valid, cell_row0, cell_row1, cell_row2, cell_row3, cell_row4,
                   cell_row5, cell_row6, cell_row7, last_column, input ready);
    modport sink(input valid, cell_row0, cell_row1, cell_row2, cell_row3, cell_row4,
                 cell_row5, cell_row6, cell_row7, last_column, output ready);
endinterface

interface gsnm_out_if;
    import gsnm_pkg::*;
    logic   valid;
    logic   ready;
    t_total best_total;
    modport source(output valid, best_total, input ready);
    modport sink(input valid, best_total, output ready);
endinterface

// File: rtl/gsnm_lane.sv
// One lane: the running total of one row pattern and its best compatible predecessor.
// Depends on gsnm_pkg.
module gsnm_lane #(
    parameter int ROWS = 8,
    parameter int NPAT = 55,
    parameter int MASK = 0
) (
    input  logic                              i_clk,
    input  gsnm_pkg::t_lane_ctl               i_ctl,
    input  gsnm_pkg::t_cell                   i_cells [ROWS],
    input  logic [$clog2(NPAT)-1:0]           i_k,
    input  gsnm_pkg::t_total                  i_head,
    input  gsnm_pkg::t_total                  i_ring,
    output gsnm_pkg::t_total                  o_tot
);
    import gsnm_pkg::*;

    localparam logic [MAX_PAT-1:0] COMPAT = compat_vec(ROWS, MASK);
    localparam logic [ROWS-1:0]    MASK_V = ROWS'(MASK);

    t_sum   r_sum, n_sum;
    t_total r_best;
    t_total r_tot, n_tot;
    t_total w_base;
    logic signed [TOT_W:0] w_wide;

    always_comb begin
        n_sum = '0;
        for (int r = 0; r < ROWS; r++)
            if (MASK_V[r]) n_sum = n_sum + SUM_W'(i_cells[r]);
    end

    always_comb begin
        w_base = i_ctl.first ? '0 : r_best;
        w_wide = {w_base[TOT_W-1], w_base} + (TOT_W+1)'(r_sum);
        if (w_wide[TOT_W] != w_wide[TOT_W-1])
            n_tot = w_wide[TOT_W] ? TOT_MIN : TOT_MAX;
        else
            n_tot = w_wide[TOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) r_sum <= n_sum;
        if (i_ctl.clr_best)
            r_best <= TOT_MIN;
        else if (i_ctl.sweep && COMPAT[i_k] && (i_head > r_best))
            r_best <= i_head;
        if (i_ctl.update)
            r_tot <= n_tot;
        else if (i_ctl.rotate)
            r_tot <= i_ring;
    end

    assign o_tot = r_tot;

endmodule

// File: rtl/gsnm_merge.sv
// Merging stage: running maximum over the ring head and the all-negative fallback.
// Depends on gsnm_pkg.
module gsnm_merge (
    input  logic                 i_clk,
    input  gsnm_pkg::t_merge_ctl i_ctl,
    input  gsnm_pkg::t_total     i_head,
    input  gsnm_pkg::t_cell      i_largest,
    output gsnm_pkg::t_total     o_result
);
    import gsnm_pkg::*;

    t_total r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr)
            r_acc <= TOT_MIN;
        else if (i_ctl.step && (i_head > r_acc))
            r_acc <= i_head;
    end

    // an all-negative table yields its largest cell, or LARGEST_RESET if every cell lies below it
    assign o_result = (i_largest < 0) ? TOT_W'(i_largest) : r_acc;

endmodule

// File: rtl/grid_strip_nonadjacent_max_sum.sv
// Top level of the grid strip nonadjacent max sum block.
// Depends on gsnm_pkg, gsnm_if, gsnm_lane and gsnm_merge.
//
//  channel   direction  payload                                   handshake
//  i_in      in         cell_row0..cell_row7, last_column          valid/ready
//  o_out     out        best_total                                 valid/ready
//
// Steps: a column beat passes load, predecessor sweep and update; the first
// column of a table skips the predecessor sweep. A last column then runs the
// final maximum over the ring and emits the result. The sweep rotates the lane
// totals past every lane, one predecessor per cycle.
// Reset clears the control state and opens a new table; totals need no reset.
// A result waiting on o_out does not block new columns; only the next result
// holds until it has been taken.
module grid_strip_nonadjacent_max_sum #(
    parameter int ROWS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gsnm_in_if.sink    i_in,
    gsnm_out_if.source o_out
);
    import gsnm_pkg::*;

    localparam int NPAT = pat_count(ROWS);
    localparam int KW   = $clog2(NPAT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_REDUCE = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [KW-1:0] r_k;
    logic          r_first;
    logic          r_last;
    t_cell         r_largest, n_largest;
    t_cell         r_cell [ROWS];
    t_cell         w_in_cell [CELL_FIELDS];
    logic          r_out_valid;
    t_total        r_out_total;
    t_total        w_tot [NPAT];
    t_total        w_result;
    t_lane_ctl     w_lane_ctl;
    t_merge_ctl    w_merge_ctl;
    logic          w_accept;
    logic          w_k_end;
    logic          w_emit;

    assign w_in_cell[0] = i_in.cell_row0;
    assign w_in_cell[1] = i_in.cell_row1;
    assign w_in_cell[2] = i_in.cell_row2;
    assign w_in_cell[3] = i_in.cell_row3;
    assign w_in_cell[4] = i_in.cell_row4;
    assign w_in_cell[5] = i_in.cell_row5;
    assign w_in_cell[6] = i_in.cell_row6;
    assign w_in_cell[7] = i_in.cell_row7;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_k_end    = (r_k == KW'(NPAT - 1));
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    // largest cell of the table so far, rows past the fields count as zero
    always_comb begin
        n_largest = r_largest;
        for (int r = 0; r < ROWS; r++)
            if (r_cell[r] > n_largest) n_largest = r_cell[r];
    end

    always_comb begin
        w_lane_ctl.load_sum = (r_state == S_LOAD);
        w_lane_ctl.clr_best = (r_state == S_LOAD);
        w_lane_ctl.sweep    = (r_state == S_SWEEP);
        w_lane_ctl.rotate   = (r_state == S_SWEEP) || (r_state == S_REDUCE);
        w_lane_ctl.update   = (r_state == S_UPDATE);
        w_lane_ctl.first    = r_first;
        w_merge_ctl.clr     = (r_state == S_UPDATE);
        w_merge_ctl.step    = (r_state == S_REDUCE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_LOAD;
            S_LOAD:   n_state = r_first ? S_UPDATE : S_SWEEP;
            S_SWEEP:  if (w_k_end) n_state = S_UPDATE;
            S_UPDATE: n_state = r_last ? S_REDUCE : S_IDLE;
            S_REDUCE: if (w_k_end) n_state = S_EMIT;
            S_EMIT:   if (w_emit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // lanes sit in a ring; lane 0 is the head that every lane watches
    for (genvar g = 0; g < NPAT; g++) begin : g_lane
        gsnm_lane #(
            .ROWS(ROWS),
            .NPAT(NPAT),
            .MASK(pat_at(ROWS, g))
        ) u_lane (
            .i_clk (i_clk),
            .i_ctl (w_lane_ctl),
            .i_cells(r_cell),
            .i_k   (r_k),
            .i_head(w_tot[0]),
            .i_ring(w_tot[(g + 1) % NPAT]),
            .o_tot (w_tot[g])
        );
    end

    gsnm_merge u_merge (
        .i_clk    (i_clk),
        .i_ctl    (w_merge_ctl),
        .i_head   (w_tot[0]),
        .i_largest(r_largest),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_first     <= 1'b1;
            r_largest   <= LARGEST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_SWEEP) || (r_state == S_REDUCE))
                r_k <= w_k_end ? '0 : r_k + 1'b1;
            else
                r_k <= '0;
            if (r_state == S_LOAD) r_largest <= n_largest;
            if (r_state == S_UPDATE) r_first <= 1'b0;
            if (w_emit) begin
                // close the table and open a new one
                r_out_valid <= 1'b1;
                r_first     <= 1'b1;
                r_largest   <= LARGEST_RESET;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_in.last_column;
            for (int r = 0; r < ROWS; r++)
                r_cell[r] <= (r < CELL_FIELDS) ? w_in_cell[r % CELL_FIELDS] : '0;
        end
        if (w_emit) r_out_total <= w_result;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.best_total = r_out_total;

    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result raised outside the emit step");

    a_last_reduces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) && r_last |=> (r_state == S_REDUCE))
        else $error("last column did not start the final maximum");

    a_first_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) && r_first |=> (r_state == S_UPDATE))
        else $error("first column entered the predecessor sweep");

endmodule

// File: bench/gsnm_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the grid strip nonadjacent max sum testbench.
// Depends on gsnm_pkg; predicts table results from accepted column beats.
package gsnm_tb_pkg;
    import gsnm_pkg::*;

    typedef struct {
        t_cell cells [8];
        logic  last;
    } t_column;

    class strip_scoreboard;
        t_total    totals [256];
        bit        first_pending;
        t_cell     largest;
        t_total    best_q [$];
        int        mismatches;
        int        results_seen;
        int        tables_seen;

        function new();
            first_pending = 1;
            largest       = LARGEST_RESET;
            mismatches    = 0;
            results_seen  = 0;
            tables_seen   = 0;
            foreach (totals[m]) totals[m] = '0;
        endfunction

        static function bit pattern_valid(int m);
            return (m & (m >> 1)) == 0;
        endfunction

        static function t_total add_saturate(t_total a, t_total b);
            logic signed [64:0] wide;
            wide = 65'(a) + 65'(b);
            if (wide > 65'(TOT_MAX)) return TOT_MAX;
            if (wide < 65'(TOT_MIN)) return TOT_MIN;
            return wide[63:0];
        endfunction

        // advance the pattern totals by one column; queue a result on the last one
        function void note_column(t_column col);
            t_total next [256];
            t_total colsum;
            t_total prev;
            t_total ans;
            for (int r = 0; r < 8; r++)
                if (col.cells[r] > largest) largest = col.cells[r];
            for (int m = 0; m < 256; m++) begin
                next[m] = '0;
                if (!pattern_valid(m)) continue;
                colsum = '0;
                for (int r = 0; r < 8; r++)
                    if ((m >> r) & 1) colsum += t_total'(col.cells[r]);
                if (first_pending) prev = '0;
                else begin
                    prev = TOT_MIN;
                    for (int p = 0; p < 256; p++)
                        if (pattern_valid(p) && (p & m) == 0 && totals[p] > prev)
                            prev = totals[p];
                end
                next[m] = add_saturate(prev, colsum);
            end
            totals        = next;
            first_pending = 0;
            if (!col.last) return;
            if (largest < 0) ans = t_total'(largest);
            else begin
                ans = TOT_MIN;
                for (int m = 0; m < 256; m++)
                    if (pattern_valid(m) && totals[m] > ans) ans = totals[m];
            end
            best_q = {best_q, ans};
            tables_seen++;
            first_pending = 1;
            largest       = LARGEST_RESET;
        endfunction

        function void check_result(t_total got);
            t_total want;
            results_seen++;
            if (best_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", got);
                return;
            end
            want = best_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("best_total: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass
endpackage

// File: bench/grid_strip_nonadjacent_max_sum_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for grid_strip_nonadjacent_max_sum.
// Depends on gsnm_pkg, gsnm_if, gsnm_tb_pkg and the block's RTL.
module grid_strip_nonadjacent_max_sum_tb;
    import gsnm_pkg::*;
    import gsnm_tb_pkg::*;

    localparam int RANDOM_COLUMNS = 930;

    logic i_clk = 0;
    logic i_rst_n = 0;
    gsnm_in_if  col_if ();
    gsnm_out_if res_if ();

    strip_scoreboard board = new();
    bit   long_hold;
    int   columns_sent;

    always #6 i_clk = ~i_clk;

    grid_strip_nonadjacent_max_sum DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (col_if),
        .o_out   (res_if)
    );

    // Sample both channels at the rising edge; feed the scoreboard in beat order.
    always @(posedge i_clk) begin
        if (i_rst_n && col_if.valid && col_if.ready) begin
            t_column c;
            c.cells[0] = col_if.cell_row0; c.cells[1] = col_if.cell_row1;
            c.cells[2] = col_if.cell_row2; c.cells[3] = col_if.cell_row3;
            c.cells[4] = col_if.cell_row4; c.cells[5] = col_if.cell_row5;
            c.cells[6] = col_if.cell_row6; c.cells[7] = col_if.cell_row7;
            c.last = col_if.last_column;
            board.note_column(c);
            columns_sent++;
        end
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_result(res_if.best_total);
    end

    // Receiver: a stall pattern of its own, plus one long hold-off on request.
    initial begin
        int phase;
        res_if.ready = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (long_hold) res_if.ready <= 0;
            else if ((phase / 40) % 3 == 2) res_if.ready <= 1;
            else res_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Present one column beat and hold it until it is taken.
    task automatic send_column(t_cell cells [8], logic last);
        col_if.valid       <= 1;
        col_if.cell_row0   <= cells[0]; col_if.cell_row1 <= cells[1];
        col_if.cell_row2   <= cells[2]; col_if.cell_row3 <= cells[3];
        col_if.cell_row4   <= cells[4]; col_if.cell_row5 <= cells[5];
        col_if.cell_row6   <= cells[6]; col_if.cell_row7 <= cells[7];
        col_if.last_column <= last;
        @(posedge i_clk);
        while (!col_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        col_if.valid <= 0;
    endtask

    // Random cell: mostly small, sometimes extreme, sometimes fully random.
    function automatic t_cell pick_cell(int mode);
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return t_cell'($urandom);
            default:
                if (mode == 1) return -t_cell'($urandom_range(1, 1000));
                else return t_cell'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic send_filled(t_cell v, logic last);
        t_cell c [8];
        foreach (c[r]) c[r] = v;
        send_column(c, last);
    endtask

    // Pause the sender until every expected result has been taken.
    task automatic drain();
        go_idle();
        while (board.best_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    initial begin
        t_cell c [8];
        int    burst;
        int    width;
        int    mode;
        int    sent;
        col_if.valid = 0;
        col_if.last_column = 0;
        {col_if.cell_row0, col_if.cell_row1, col_if.cell_row2, col_if.cell_row3} = '0;
        {col_if.cell_row4, col_if.cell_row5, col_if.cell_row6, col_if.cell_row7} = '0;
        long_hold = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: single and multi-column tables, extremes, all-negative, saturation.
        send_filled(32'sh7FFFFFFF, 1);
        send_filled(32'sh80000000, 1);
        send_filled(0, 1);
        send_filled(-1, 1);
        for (int r = 0; r < 8; r++) begin
            foreach (c[k]) c[k] = -5;
            c[r] = 1000 + r;
            send_column(c, 1);
        end
        for (int k = 0; k < 4; k++) send_filled(-7 - k, k == 3);
        // long positive table to push totals high
        for (int k = 0; k < 6; k++) send_filled(32'sh7FFFFFFF, k == 5);
        for (int k = 0; k < 3; k++) send_filled(32'sh80000000, k == 2);
        drain();

        // Long hold-off: the block fills up while the sender keeps offering.
        long_hold = 1;
        fork
            begin
                repeat (1500) @(negedge i_clk);
                long_hold = 0;
            end
            begin
                for (int k = 0; k < 12; k++) begin
                    foreach (c[r]) c[r] = pick_cell(0);
                    send_column(c, k % 3 == 0);
                end
                go_idle();
            end
        join
        drain();

        // Random tables of mostly short width, sent in bursts with gaps.
        sent = 0;
        burst = 0;
        while (sent < RANDOM_COLUMNS) begin
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25)
                                                  : $urandom_range(1, 5);
            mode  = ($urandom_range(0, 5) == 0) ? 1 : 0;
            for (int k = 0; k < width; k++) begin
                if (burst == 0) begin
                    go_idle();
                    repeat ($urandom_range(0, 30)) @(negedge i_clk);
                    burst = $urandom_range(1, 20);
                end
                foreach (c[r]) c[r] = pick_cell(mode);
                send_column(c, k == width - 1);
                burst--;
                sent++;
            end
            if (sent > 450 && sent < 460) drain();
        end
        go_idle();
        while (board.best_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        $display("Covered %0d columns in %0d tables; %0d results checked.",
                 columns_sent, board.tables_seen, board.results_seen);
        if (board.mismatches == 0 && board.best_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
